// ===== rtl/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// bad_pkg: shared types and constants of the block average downsampler
// Sizes, register indexes and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package bad_pkg;

    // Frame and block limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_BLOCK  = 4;

    // Field and register widths.
    localparam int PIX_W     = 8;
    localparam int BS_W      = 3;
    localparam int DIM_W     = 12;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int OFF_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int RUN_W     = $clog2(MAX_BLOCK * 255 + 1);
    localparam int BAND_W    = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
    localparam int CNT_W     = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int DIV_CNT_W = $clog2(BAND_W);

    // Stream packing.
    localparam int IN_TDATA_W  = 3 * PIX_W;
    localparam int OUT_USED_W  = 3 * PIX_W + COL_W + ROW_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_COL_LSB = 3 * PIX_W;
    localparam int OUT_ROW_LSB = 3 * PIX_W + COL_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [BS_W-1:0]  BS_RESET     = 3'd1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic accept;     // pixel transfer this cycle
        logic cfg_write;  // configuration transfer this cycle
        logic acc;        // accumulate the column sum into the band store
        logic div_step;   // one quotient bit on all three channels
        logic out_load;   // move the quotients into the output register
    } cmd_t;

    typedef struct packed {
        logic col_end;    // the pending pixel closes a block column
        logic block_end;  // the latched column also closes its block
        logic out_free;   // output register can take a new result
    } status_t;

endpackage

// ===== rtl/bad_ram.sv =====
// ----------------------------------------------------------------------------
// bad_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bad_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/bad_ctrl.sv =====
// ----------------------------------------------------------------------------
// bad_ctrl: sequencer of the block average downsampler
// Takes pixels, steps the band update and the shared divider, and hands
// finished blocks to the output register.
// ----------------------------------------------------------------------------
module bad_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  bad_pkg::status_t st,
    output bad_pkg::cmd_t    cmd
);
    import bad_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(BAND_W - 1);

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        cfg_ready    = 1'b1;
        cmd.cfg_write = cfg_valid;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && st.col_end) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc   = 1'b1;
                step_next = '0;
                if (st.block_end) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule

// ===== rtl/bad_datapath.sv =====
// ----------------------------------------------------------------------------
// bad_datapath: counters, sums, band store, divider and output register
// Holds the configuration, the raster position, the running sums of the
// current block row and the per-column band sums, and divides each closed
// block by its real pixel count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bad_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bad_pkg::cmd_t                       cmd,
    output bad_pkg::status_t                    st,
    input  logic [bad_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [bad_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bad_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bad_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import bad_pkg::*;

    // Configuration.
    logic [BS_W-1:0]  bs_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             restart;

    // Raster position.
    logic [COL_W-1:0] pixel_col_reg, out_col_reg;
    logic [ROW_W-1:0] pixel_row_reg, out_row_reg;
    logic [OFF_W-1:0] col_off_reg, row_off_reg;

    // Clamped limits minus one.
    logic [OFF_W-1:0] bs_m1;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             last_col, last_row, col_end, row_end;

    // Sums and per-block latches.
    logic [RUN_W-1:0]  run_reg   [3];
    logic [RUN_W-1:0]  run_next  [3];
    logic [RUN_W-1:0]  colsum_reg[3];
    logic [COL_W-1:0]  slot_reg;
    logic              first_reg, block_end_reg, frame_end_reg;
    logic [COL_W-1:0]  blk_col_reg;
    logic [ROW_W-1:0]  blk_row_reg;
    logic [CNT_W-1:0]  count_reg;

    // Band store.
    logic [3*BAND_W-1:0] ram_rdata, ram_wdata;
    logic [BAND_W-1:0]   band_sum[3];

    // Divider.
    logic [BAND_W-1:0] quo_reg[3];
    logic [CNT_W-1:0]  rem_reg[3];
    logic [CNT_W:0]    trial  [3];

    // Output register.
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg;

    always_comb begin
        if (bs_reg == '0) begin
            bs_m1 = '0;
        end else if (int'(bs_reg) > MAX_BLOCK) begin
            bs_m1 = OFF_W'(MAX_BLOCK - 1);
        end else begin
            bs_m1 = OFF_W'(bs_reg - 1'b1);
        end
        if (width_reg == '0) begin
            w_m1 = '0;
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = COL_W'(width_reg - 1'b1);
        end
        if (height_reg == '0) begin
            h_m1 = '0;
        end else if (int'(height_reg) > MAX_HEIGHT) begin
            h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = ROW_W'(height_reg - 1'b1);
        end
    end

    assign last_col = (pixel_col_reg >= w_m1);
    assign last_row = (pixel_row_reg >= h_m1);
    assign col_end  = (col_off_reg >= bs_m1) || last_col;
    assign row_end  = (row_off_reg >= bs_m1) || last_row;

    assign restart = cmd.cfg_write && (cfg_index == REG_BLOCK_SIDE
                     || cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg     <= BS_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cmd.cfg_write) begin
            unique case (cfg_index)
                REG_BLOCK_SIDE:   bs_reg     <= cfg_data[BS_W-1:0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            pixel_col_reg <= '0;
            pixel_row_reg <= '0;
            col_off_reg   <= '0;
            row_off_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
        end else if (cmd.accept) begin
            if (last_col) begin
                pixel_col_reg <= '0;
                col_off_reg   <= '0;
                out_col_reg   <= '0;
                if (last_row) begin
                    pixel_row_reg <= '0;
                    row_off_reg   <= '0;
                    out_row_reg   <= '0;
                end else begin
                    pixel_row_reg <= pixel_row_reg + 1'b1;
                    if (row_end) begin
                        row_off_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end else begin
                        row_off_reg <= row_off_reg + 1'b1;
                    end
                end
            end else begin
                pixel_col_reg <= pixel_col_reg + 1'b1;
                if (col_end) begin
                    col_off_reg <= '0;
                    out_col_reg <= out_col_reg + 1'b1;
                end else begin
                    col_off_reg <= col_off_reg + 1'b1;
                end
            end
        end
    end

    // Running sum of the current block row.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            run_next[c] = run_reg[c] + RUN_W'(s_tdata[c*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int c = 0; c < 3; c++) begin
                run_reg[c] <= '0;
            end
        end else if (cmd.accept) begin
            for (int c = 0; c < 3; c++) begin
                run_reg[c] <= col_end ? '0 : run_next[c];
            end
        end
    end

    // Latches for the column or block that the accepted pixel closes.
    always_ff @(posedge aclk) begin
        if (cmd.accept && col_end) begin
            for (int c = 0; c < 3; c++) begin
                colsum_reg[c] <= run_next[c];
            end
            slot_reg      <= out_col_reg;
            first_reg     <= (row_off_reg == '0);
            block_end_reg <= row_end;
            frame_end_reg <= last_col && last_row;
            blk_col_reg   <= out_col_reg;
            blk_row_reg   <= out_row_reg;
            count_reg     <= CNT_W'((CNT_W'(col_off_reg) + 1'b1)
                                    * (CNT_W'(row_off_reg) + 1'b1));
        end
    end

    // Band store update: the first row of a band overwrites its slot.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            band_sum[c] = (first_reg ? '0 : ram_rdata[c*BAND_W +: BAND_W])
                          + BAND_W'(colsum_reg[c]);
            ram_wdata[c*BAND_W +: BAND_W] = band_sum[c];
        end
    end

    bad_ram #(
        .WIDTH (3 * BAND_W),
        .DEPTH (MAX_WIDTH)
    ) u_band_ram (
        .aclk  (aclk),
        .we    (cmd.acc),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (out_col_reg),
        .rdata (ram_rdata)
    );

    // Restoring divider, one quotient bit per channel per step.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {rem_reg[c], quo_reg[c][BAND_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            for (int c = 0; c < 3; c++) begin
                quo_reg[c] <= band_sum[c];
                rem_reg[c] <= '0;
            end
        end else if (cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                if (trial[c] >= {1'b0, count_reg}) begin
                    rem_reg[c] <= CNT_W'(trial[c] - {1'b0, count_reg});
                    quo_reg[c] <= {quo_reg[c][BAND_W-2:0], 1'b1};
                end else begin
                    rem_reg[c] <= trial[c][CNT_W-1:0];
                    quo_reg[c] <= {quo_reg[c][BAND_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output register.
    always_comb begin
        m_tdata_next = '0;
        for (int c = 0; c < 3; c++) begin
            m_tdata_next[c*PIX_W +: PIX_W] = quo_reg[c][PIX_W-1:0];
        end
        m_tdata_next[OUT_COL_LSB +: COL_W] = blk_col_reg;
        m_tdata_next[OUT_ROW_LSB +: ROW_W] = blk_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= frame_end_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tlast      = m_tlast_reg;
    assign st.col_end   = col_end;
    assign st.block_end = block_end_reg;
    assign st.out_free  = !m_tvalid_reg || m_tready;
endmodule

// ===== rtl/block_average_downsampler.sv =====
// ----------------------------------------------------------------------------
// block_average_downsampler: box filter with decimation
// Averages three-channel pixels over square blocks of a raster image and
// emits one averaged pixel per block, edge blocks divided by their real size.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload (lowest bit first)             Handshake
//   s_        in         blue_in, green_in, red_in in s_tdata   s_tvalid/s_tready
//   m_        out        blue_avg, green_avg, red_avg,          m_tvalid/m_tready
//                        block_col, block_row in m_tdata;
//                        frame_end in m_tlast
//   cfg_      in         register index, write data            cfg_valid/cfg_ready
//
// A pixel that does not close a block column is simply taken. A pixel that
// closes a column of a block but not the block also reads the band store as
// it is taken and then writes the updated column sum back. A pixel that
// closes a block also runs the shared restoring divider, which produces one
// quotient bit of all three channels per cycle over the twelve-bit block
// sum, and then loads the output register once it is free.
// Reset is synchronous and active low; the band store needs no clearing pass,
// since the first row of every band overwrites its entries before they are
// read. A stalled output only holds the block at the divider when a second
// result is ready; pixels keep flowing while a result waits.
// ----------------------------------------------------------------------------
module block_average_downsampler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Pixel input: blue_in [7:0], green_in [15:8], red_in [23:16].
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bad_pkg::IN_TDATA_W-1:0]       s_tdata,
    // Block results: blue_avg [7:0], green_avg [15:8], red_avg [23:16],
    // block_col [34:24], block_row [45:35], zero fill above.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bad_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    // Configuration writes: 0 block side, 1 image width, 2 image height.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bad_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bad_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bad_pkg::*;

    cmd_t    cmd;
    status_t st;

    // The controller decides when a pixel transfer happens and sequences
    // the band update, the division and the output load.
    bad_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // The datapath owns every counter but the divider step, every sum and the output register.
    bad_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );
endmodule
